FILE: rtl/core/bvg_pkg.sv
// shared types and constants of the battery voltage gauge
`timescale 1ns / 1ps
`default_nettype none

package bvg_pkg;

    // item selector carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_VREQ   = 2'd2,
        FUNC_PREQ   = 2'd3
    } func_t;

    // register index, byte address divided by four
    typedef enum logic [1:0] {
        REG_MAX_MV   = 2'd0,
        REG_MIN_MV   = 2'd1,
        REG_VHOLD_MS = 2'd2,
        REG_PHOLD_MS = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VLOAD,
        ST_PLOAD,
        ST_PDIV,
        ST_RESP
    } state_t;

    localparam int SAMPLES_DEFAULT = 10;

    // divider operand widths
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 16;

    localparam int MV_W    = 13;
    localparam int PCT_W   = 7;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W   = 16;
    localparam int AGE_W   = 16;

    // full scale in mV: 2 * 3.3 V * 1100
    localparam logic [12:0] FULL_SCALE_MV = 13'd7260;
    localparam int          ADC_MAX       = 4095;
    localparam logic [12:0] USB_HIGH_MV   = 13'd4500;
    localparam logic [12:0] USB_LOW_MV    = 13'd1000;
    localparam logic [6:0]  PCT_FULL      = 7'd100;

    localparam logic [15:0] VHOLD_RESET = 16'd2500;
    localparam logic [15:0] PHOLD_RESET = 16'd10000;

endpackage

`default_nettype wire

FILE: rtl/core/bvg_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bvg_div
    import bvg_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  busy,
    output logic [NUM_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/battery_voltage_gauge.sv
// battery voltage gauge top level: sequencer, state, config port, output register
//
// usage
//   input stream s_*: one transfer per item; s_tuser selects tick, adc sample,
//   voltage request or percent request; s_tdata carries the sample and force bit
//   output stream m_*: exactly one transfer per input item, holding the stored
//   voltage, percent, usb flag, busy flag and the new-voltage mark after that item
//   config: apb-style, four registers at byte addresses 0, 4, 8, 12, pready tied high
// sequencing
//   one item at a time; s_tready is low from acceptance until the result is loaded
//   ticks, voltage requests, ordinary samples and waiting percent requests: ST_RESP loads
//   a closing sample averages by one reciprocal multiply in ST_VLOAD before ST_RESP
//   a percent divide runs the divider from ST_PLOAD through ST_PDIV to ST_RESP,
//   for a percent request or after a closing sample with a percent request pending
// reset
//   all stored values clear, hold times return to 2500 and 10000 ms, no voltage yet
// stall
//   a result waits in the output register; the block accepts the next item and
//   works on it, but loads its result only once the previous one is taken
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_gauge
    import bvg_pkg::*;
#(
    parameter int SAMPLES_PER_MEASURE = SAMPLES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // adc_sample[11:0], force_req[12], zero pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // voltage_mv[12:0], battery_percent[19:13],
                                        // usb_powered[20], busy_res[21],
                                        // new_voltage[22], zero pad
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // count compare is one bit wider so a full count of 16 fits
    localparam logic [4:0]  SPM     = 5'(SAMPLES_PER_MEASURE);
    // averaging denominator: full adc code times the sample count
    localparam logic [63:0] AVG_DEN = 64'(ADC_MAX * SAMPLES_PER_MEASURE);
    // full scale over the denominator, scaled by 2^32 and rounded up; exact for
    // any 16-bit sum while the denominator stays below 2^16
    localparam logic [32:0] AVG_MUL =
        33'(((64'(FULL_SCALE_MV) << 32) + AVG_DEN - 64'd1) / AVG_DEN);

    // state registers
    state_t               state_reg, state_next;
    logic [MV_W-1:0]      max_mv_reg, max_mv_next;
    logic [MV_W-1:0]      min_mv_reg, min_mv_next;
    logic [AGE_W-1:0]     vhold_reg, vhold_next;
    logic [AGE_W-1:0]     phold_reg, phold_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [3:0]           count_reg, count_next;
    logic                 measuring_reg, measuring_next;
    logic [MV_W-1:0]      volt_reg, volt_next;
    logic [AGE_W-1:0]     vage_reg, vage_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [AGE_W-1:0]     page_reg, page_next;
    logic                 once_reg, once_next;
    logic                 pending_reg, pending_next;
    logic                 done_reg, done_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [23:0]          m_tdata_reg, m_tdata_next;

    // divider for the percent calculation
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quotient;

    // decoded input and helpers
    logic                 in_xfer;
    func_t                in_func;
    logic [SAMPLE_W-1:0]  in_sample;
    logic                 in_force;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic                 limits_zero;
    logic                 fresh_v;
    logic [SUM_W-1:0]     sum_add;
    logic [4:0]           cnt_inc;
    logic [48:0]          avg_prod;
    logic [MV_W-1:0]      range_mv;
    logic [MV_W-1:0]      drop_mv;
    logic [19:0]          pct_num;
    logic [20:0]          pct_num_ceil;
    logic [PCT_W-1:0]     pct_out;
    logic                 usb_flag;

    assign in_xfer   = s_tvalid && s_tready;
    assign in_func   = func_t'(s_tuser);
    assign in_sample = s_tdata[11:0];
    assign in_force  = s_tdata[12];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    assign limits_zero = (max_mv_reg == '0) || (min_mv_reg == '0);
    assign fresh_v     = (volt_reg != '0) && (vage_reg < vhold_reg);
    assign sum_add     = sum_reg + {4'b0, in_sample};
    assign cnt_inc     = {1'b0, count_reg} + 5'd1;

    // average by reciprocal multiply, quotient starts at bit 32
    assign avg_prod     = {33'b0, sum_reg} * {16'b0, AVG_MUL};
    // numerator for the percent divide
    assign range_mv     = max_mv_reg - min_mv_reg;
    assign drop_mv      = max_mv_reg - volt_reg;
    assign pct_num      = 20'(drop_mv * PCT_FULL);
    // ceiling division: add divisor minus one
    assign pct_num_ceil = {1'b0, pct_num} + {8'b0, range_mv} - 21'd1;

    assign pct_out  = limits_zero ? '0 : pct_reg;
    assign usb_flag = (volt_reg > USB_HIGH_MV) || (volt_reg < USB_LOW_MV);

    bvg_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // sequencer: next state, state updates and divider control
    always_comb
    begin
        state_next     = state_reg;
        max_mv_next    = max_mv_reg;
        min_mv_next    = min_mv_reg;
        vhold_next     = vhold_reg;
        phold_next     = phold_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        measuring_next = measuring_reg;
        volt_next      = volt_reg;
        vage_next      = vage_reg;
        pct_next       = pct_reg;
        page_next      = page_reg;
        once_next      = once_reg;
        pending_next   = pending_reg;
        done_next      = done_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        // register writes are to arrive only while idle; the block does not enforce this
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MAX_MV:   max_mv_next = pwdata[MV_W-1:0];
                REG_MIN_MV:   min_mv_next = pwdata[MV_W-1:0];
                REG_VHOLD_MS: vhold_next  = pwdata[AGE_W-1:0];
                REG_PHOLD_MS: phold_next  = pwdata[AGE_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    done_next  = 1'b0;
                    state_next = ST_RESP;
                    case (in_func)
                        FUNC_TICK:
                        begin
                            // ages saturate
                            if (vage_reg != '1)
                                vage_next = vage_reg + 1'b1;
                            if (page_reg != '1)
                                page_next = page_reg + 1'b1;
                        end
                        FUNC_SAMPLE:
                        begin
                            if (measuring_reg)
                            begin
                                sum_next = sum_add;
                                if (cnt_inc >= SPM)
                                begin
                                    count_next = '0;
                                    state_next = ST_VLOAD;
                                end
                                else
                                begin
                                    count_next = cnt_inc[3:0];
                                end
                            end
                        end
                        FUNC_VREQ:
                        begin
                            if ((in_force || !fresh_v) && !measuring_reg)
                            begin
                                measuring_next = 1'b1;
                                sum_next       = '0;
                                count_next     = '0;
                            end
                        end
                        FUNC_PREQ:
                        begin
                            if (!limits_zero &&
                                !(!in_force && once_reg && (page_reg < phold_reg)))
                            begin
                                if (fresh_v)
                                begin
                                    state_next = ST_PLOAD;
                                end
                                else
                                begin
                                    pending_next = 1'b1;
                                    if (!measuring_reg)
                                    begin
                                        measuring_next = 1'b1;
                                        sum_next       = '0;
                                        count_next     = '0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_VLOAD:
            begin
                // average: sum * full scale / (adc max * samples)
                volt_next      = avg_prod[32 +: MV_W];
                vage_next      = '0;
                measuring_next = 1'b0;
                done_next      = 1'b1;
                state_next     = ST_RESP;
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    if (!limits_zero)
                        state_next = ST_PLOAD;
                end
            end

            ST_PLOAD:
            begin
                if (max_mv_reg <= min_mv_reg)
                begin
                    // inverted or empty range
                    pct_next   = (volt_reg >= max_mv_reg) ? PCT_FULL : '0;
                    page_next  = '0;
                    once_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else if (volt_reg >= max_mv_reg)
                begin
                    pct_next   = PCT_FULL;
                    page_next  = '0;
                    once_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_NUM_W'(pct_num_ceil);
                    div_divisor  = DIV_DEN_W'(range_mv);
                    state_next   = ST_PDIV;
                end
            end

            ST_PDIV:
            begin
                if (!div_busy)
                begin
                    // quotient is the ceiling of the drop in percent
                    if (div_quotient > DIV_NUM_W'(PCT_FULL))
                        pct_next = '0;
                    else
                        pct_next = PCT_FULL - div_quotient[PCT_W-1:0];
                    page_next  = '0;
                    once_next  = 1'b1;
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                // load the result once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, done_reg, measuring_reg, usb_flag,
                                     pct_out, volt_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_mv_reg    <= '0;
            min_mv_reg    <= '0;
            vhold_reg     <= VHOLD_RESET;
            phold_reg     <= PHOLD_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            measuring_reg <= 1'b0;
            volt_reg      <= '0;
            vage_reg      <= '0;
            pct_reg       <= '0;
            page_reg      <= '0;
            once_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            done_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_mv_reg    <= max_mv_next;
            min_mv_reg    <= min_mv_next;
            vhold_reg     <= vhold_next;
            phold_reg     <= phold_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            measuring_reg <= measuring_next;
            volt_reg      <= volt_next;
            vage_reg      <= vage_next;
            pct_reg       <= pct_next;
            page_reg      <= page_next;
            once_reg      <= once_next;
            pending_reg   <= pending_next;
            done_reg      <= done_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_MAX_MV:   prdata = {19'b0, max_mv_reg};
            REG_MIN_MV:   prdata = {19'b0, min_mv_reg};
            REG_VHOLD_MS: prdata = {16'b0, vhold_reg};
            REG_PHOLD_MS: prdata = {16'b0, phold_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // one item in flight: an accepted transfer closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("input accepted while previous item still in work");

    // the divider is never restarted while a job runs
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a reported percent never exceeds full charge
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:13] <= PCT_FULL))
        else $error("percent above 100");

    // a finished measurement is never reported as still collecting
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[22]) |-> !m_tdata[21])
        else $error("new voltage reported while busy");

endmodule

`default_nettype wire
